// ===== hdl/ili_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ili_pkg: shared types and constants of the indexed list
// Action and status codes, the shift command that drives the row of cells,
// and the fixed field widths.
// ----------------------------------------------------------------------------
package ili_pkg;

    localparam int unsigned CAPACITY_DEF = 256;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned POS_W        = 9;
    localparam int unsigned ACT_W        = 3;
    localparam int unsigned STAT_W       = 2;
    localparam int unsigned RD_GROUP     = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ      = 3'd0,
        ACT_ADD_HEAD  = 3'd1,
        ACT_ADD_TAIL  = 3'd2,
        ACT_ADD_INDEX = 3'd3,
        ACT_DELETE    = 3'd4
    } act_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] data;
    } cell_cmd_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_REDUCE = 1'b1
    } state_t;

endpackage : ili_pkg
`default_nettype wire

// ===== hdl/ili_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ili_cell: one list slot
// Holds one entry. On an insert, cells after pos take their left neighbor's
// entry, the one at pos the new word; on a delete, all from pos the right's.
// ----------------------------------------------------------------------------
module ili_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned IW  = 8
) (
    input  wire logic                       clk,
    input  wire ili_pkg::cell_cmd_t         cmd,
    input  wire logic [IW-1:0]              pos,
    input  wire logic [ili_pkg::DATA_W-1:0] left_value,
    input  wire logic [ili_pkg::DATA_W-1:0] right_value,
    output logic      [ili_pkg::DATA_W-1:0] value,
    output logic      [ili_pkg::DATA_W-1:0] tap
);
    import ili_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              hit;
    logic              after;

    assign hit   = (pos == MY_IDX);
    assign after = (MY_IDX > pos);

    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (hit)
                begin
                    value_next = cmd.data;
                end
                else if (after)
                begin
                    value_next = left_value;
                end
            end
            OP_DELETE:
            begin
                if (hit || after)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign tap   = hit ? value_reg : '0;

endmodule : ili_cell
`default_nettype wire

// ===== hdl/ili_chain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ili_chain: row of list cells with a registered read-out tree
// Every cell shifts in the same cycle. A read ORs the selected cell's tap
// through one register level of groups and a final OR over the groups.
// ----------------------------------------------------------------------------
module ili_chain #(
    parameter int unsigned CAPACITY = ili_pkg::CAPACITY_DEF,
    parameter int unsigned IW       = $clog2(CAPACITY)
) (
    input  wire logic                       clk,
    input  wire ili_pkg::cell_cmd_t         cmd,
    input  wire logic [IW-1:0]              pos,
    output logic      [ili_pkg::DATA_W-1:0] rd_value
);
    import ili_pkg::*;

    localparam int unsigned NG = (CAPACITY + RD_GROUP - 1) / RD_GROUP;

    logic [DATA_W-1:0] cval [CAPACITY];
    logic [DATA_W-1:0] ctap [CAPACITY];
    logic [DATA_W-1:0] grp_reg [NG];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_v;
        logic [DATA_W-1:0] right_v;

        // The end cells see their own entry where no neighbor exists.
        if (i == 0)
        begin : g_first
            assign left_v = cval[i];
        end
        else
        begin : g_mid_l
            assign left_v = cval[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_v = cval[i];
        end
        else
        begin : g_mid_r
            assign right_v = cval[i+1];
        end

        ili_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .pos         (pos),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cval[i]),
            .tap         (ctap[i])
        );
    end

    for (genvar g = 0; g < NG; g++)
    begin : g_group
        logic [DATA_W-1:0] grp_next;

        always_comb
        begin
            grp_next = '0;
            for (int k = 0; k < RD_GROUP; k++)
            begin
                if (g * RD_GROUP + k < CAPACITY)
                begin
                    grp_next = grp_next | ctap[g * RD_GROUP + k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            grp_reg[g] <= grp_next;
        end
    end

    always_comb
    begin
        rd_value = '0;
        for (int g = 0; g < NG; g++)
        begin
            rd_value = rd_value | grp_reg[g];
        end
    end

endmodule : ili_chain
`default_nettype wire

// ===== hdl/indexed_list_insert_delete.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: bounded ordered list of signed 32-bit values
// Read, add at head, tail or index, and delete, on a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel   handshake              word
//  ------    ---------------------  -------------------------------------
//  in        in_valid / in_ready    action, position, item_value
//  out       out_valid / out_ready  read_value, status, list_length
//
// In the accept cycle every cell shifts at once and the read groups are
// captured; the next cycle finishes the read-out OR tree and loads the
// result register. No new word is taken while a word is being read out.
// A stalled result holds in_ready low until it is taken. Reset clears the
// length; entries past the length are never read.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete #(
    parameter int unsigned CAPACITY = ili_pkg::CAPACITY_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [ili_pkg::ACT_W-1:0]  action,
    input  wire logic [ili_pkg::POS_W-1:0]  position,
    input  wire logic signed [ili_pkg::DATA_W-1:0] item_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [ili_pkg::DATA_W-1:0] read_value,
    output logic      [ili_pkg::STAT_W-1:0] status,
    output logic      [ili_pkg::POS_W-1:0]  list_length
);
    import ili_pkg::*;

    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    state_t            state_reg;
    state_t            state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    stat_t             st_reg;
    stat_t             st_next;
    logic              rd_ok_reg;
    logic              rd_ok_next;
    logic [DATA_W-1:0] read_value_reg;
    logic [STAT_W-1:0] status_reg;
    logic [POS_W-1:0]  length_reg;

    logic              accept;
    logic              load_out;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     sel_x;
    cell_cmd_t         cmd;
    logic [DATA_W-1:0] chain_rd;

    assign accept = in_valid && in_ready;
    assign pos_x  = XW'(position);
    assign cnt_x  = XW'(count_reg);

    // Request decode against the current length.
    always_comb
    begin
        cmd.op     = OP_NONE;
        cmd.data   = item_value;
        st_next    = ST_DONE;
        rd_ok_next = 1'b0;
        sel_x      = pos_x;
        count_next = count_reg;
        case (act_t'(action))
            ACT_READ:
            begin
                if (pos_x < cnt_x)
                begin
                    rd_ok_next = 1'b1;
                end
                else
                begin
                    st_next = ST_RANGE;
                end
            end
            ACT_ADD_HEAD, ACT_ADD_TAIL, ACT_ADD_INDEX:
            begin
                if (act_t'(action) == ACT_ADD_HEAD)
                begin
                    sel_x = '0;
                end
                else if (act_t'(action) == ACT_ADD_TAIL)
                begin
                    sel_x = cnt_x;
                end
                if ((act_t'(action) == ACT_ADD_INDEX) && (pos_x > cnt_x))
                begin
                    st_next = ST_RANGE;
                end
                else if (count_reg == CAP_CNT)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    cmd.op     = OP_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_DELETE:
            begin
                if (pos_x < cnt_x)
                begin
                    cmd.op     = OP_DELETE;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    st_next = ST_RANGE;
                end
            end
            default:
            begin
                st_next = ST_DONE;
            end
        endcase
        if (!accept)
        begin
            cmd.op     = OP_NONE;
            count_next = count_reg;
        end
    end

    ili_chain #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_chain (
        .clk      (clk),
        .cmd      (cmd),
        .pos      (IW'(sel_x)),
        .rd_value (chain_rd)
    );

    // Next state.
    always_comb
    begin
        case (state_reg)
            S_IDLE:   state_next = accept ? S_REDUCE : S_IDLE;
            S_REDUCE: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                load_out = 1'b0;
            end
            S_REDUCE:
            begin
                in_ready = 1'b0;
                load_out = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg    <= st_next;
            rd_ok_reg <= rd_ok_next;
        end
        if (load_out)
        begin
            read_value_reg <= rd_ok_reg ? chain_rd : '1;
            status_reg     <= st_reg;
            length_reg     <= POS_W'(count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign list_length = length_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("list length exceeds capacity");

    a_accept_reduce : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_REDUCE) && !in_ready)
        else $error("accepted word did not enter the read-out cycle");

    a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.op == OP_INSERT)) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list by one");

    a_full_length : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (list_length == POS_W'(CAPACITY)))
        else $error("full status reported with a list that is not full");

endmodule : indexed_list_insert_delete
`default_nettype wire
